// File: hdl/swt_pkg.sv
// Shared package of the search word tokenizer.
// Holds widths, codepoint constants, controller types and position helpers.
// No dependencies.
package swt_pkg;

  localparam int MAX_TOKEN = 32;
  localparam int IDX_W     = $clog2(MAX_TOKEN);
  localparam int LEN_W     = (IDX_W > 6) ? IDX_W : 6;
  localparam int CP_W      = 21;
  localparam int POS_W     = 16;
  localparam int WLEN_W    = 6;

  localparam logic [CP_W-1:0]  CP_DOT    = 21'h00002E;
  localparam logic [CP_W-1:0]  CP_APOS   = 21'h000027;
  localparam logic [CP_W-1:0]  CP_HYPHEN = 21'h00002D;
  localparam logic [POS_W-1:0] POS_MAX   = 16'hFFFF;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EMIT
  } swt_state_e;

  typedef struct packed {
    logic accept;
    logic issue;
  } swt_cmd_t;

  typedef struct packed {
    logic plan_any;
    logic slot_free;
    logic last_issue;
  } swt_status_t;

  function automatic logic [POS_W-1:0] pos_inc(input logic [POS_W-1:0] p);
    return (p == POS_MAX) ? POS_MAX : p + POS_W'(1);
  endfunction

  function automatic logic [POS_W-1:0] pos_dec(input logic [POS_W-1:0] p);
    return (p == '0) ? '0 : p - POS_W'(1);
  endfunction

endpackage

// File: hdl/swt_ctrl.sv
// Controller of the search word tokenizer: accept and emit sequencing.
// Depends on swt_pkg; drives commands to swt_datapath.
module swt_ctrl import swt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  swt_status_t status_i,
  output swt_cmd_t    cmd_o
);

  swt_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cmd_o.accept = 1'b0;
    cmd_o.issue  = 1'b0;
    in_stall_o   = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && status_i.plan_any) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd_o.issue = status_i.slot_free;
        if (status_i.slot_free && status_i.last_issue) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/swt_datapath.sv
// Datapath of the search word tokenizer: token store, word state, emit
// counters and output register. Depends on swt_pkg; commanded by swt_ctrl.
module swt_datapath import swt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  swt_cmd_t          cmd_i,
  output swt_status_t       status_o,
  input  logic [CP_W-1:0]   codepoint_i,
  input  logic              word_class_i,
  input  logic              end_of_text_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [CP_W-1:0]   out_char_o,
  output logic [POS_W-1:0]  word_position_o,
  output logic [WLEN_W-1:0] word_length_o,
  output logic              last_of_word_o,
  output logic              last_of_run_o
);

  logic [CP_W-1:0]  mem_q [MAX_TOKEN];
  logic [CP_W-1:0]  rd_q;

  logic [IDX_W-1:0] tok_len_q, part_q;
  logic             abbr_q, hyph_q;
  logic [POS_W-1:0] next_pos_q;

  logic [IDX_W-1:0] cur_start_q, cur_len_q, k_q, pend_len_q;
  logic [POS_W-1:0] cur_pos_q, pend_pos_q;
  logic             pend_valid_q;

  logic             s1_valid_q, s1_low_q, s1_lor_q;
  logic [IDX_W-1:0] s1_len_q;
  logic [POS_W-1:0] s1_pos_q;

  logic             out_valid_q;
  logic [CP_W-1:0]  out_char_q;
  logic [POS_W-1:0] out_pos_q;
  logic [IDX_W-1:0] out_len_q;
  logic             out_low_q, out_lor_q;

  logic             is_dot, is_apos, is_hyph;
  logic             dot_drop, apos_drop, hyph_br, end_word, joined;
  logic [IDX_W-1:0] len1, part1, len2, part2;
  logic             abbr2, hyph1, hyph2;
  logic [POS_W-1:0] pos1, pos2, pos3;
  logic             a_valid, b_valid;
  logic [IDX_W-1:0] a_start, a_len, b_len;
  logic [POS_W-1:0] a_pos, b_pos;

  logic [IDX_W-1:0] rd_addr;
  logic             last_char, s1_move;
  logic [LEN_W-1:0] len_ext;

  always_comb begin
    is_dot    = codepoint_i == CP_DOT;
    is_apos   = codepoint_i == CP_APOS;
    is_hyph   = codepoint_i == CP_HYPHEN;
    len1      = tok_len_q + IDX_W'(word_class_i);
    dot_drop  = !word_class_i && is_dot && ((tok_len_q == IDX_W'(1)) || abbr_q);
    apos_drop = !word_class_i && !dot_drop && is_apos;
    hyph_br   = !word_class_i && !dot_drop && !is_apos && is_hyph && (tok_len_q != '0);
    end_word  = end_of_text_i ||
                (!word_class_i && !dot_drop && !is_apos && !hyph_br);
    abbr2     = abbr_q | dot_drop | apos_drop;
    hyph1     = hyph_q | hyph_br;
    part1     = hyph_br ? tok_len_q : part_q;
    pos1      = next_pos_q;
    a_valid   = 1'b0;
    a_start   = part_q;
    a_len     = tok_len_q - part_q;
    a_pos     = next_pos_q;
    if (hyph_br) begin
      a_valid = tok_len_q > part_q;
      pos1    = pos_inc(next_pos_q);
    end
    b_valid = 1'b0;
    b_len   = len1;
    pos2    = pos1;
    b_pos   = pos1;
    pos3    = pos1;
    joined  = 1'b0;
    len2    = len1;
    part2   = part1;
    hyph2   = hyph1;
    if (end_word && (len1 != '0)) begin
      joined = 1'b1;
      if (hyph1) begin
        if (len1 > part1) begin
          a_valid = 1'b1;
          a_start = part1;
          a_len   = len1 - part1;
          a_pos   = pos1;
          pos2    = pos_dec(pos1);
        end else begin
          joined = 1'b0;
        end
      end
      b_pos = pos2;
      pos3  = pos2;
      if (joined) begin
        b_valid = 1'b1;
        pos3    = pos_inc(pos2);
      end
      len2  = '0;
      part2 = '0;
      abbr2 = 1'b0;
      hyph2 = 1'b0;
    end
    if (len2 >= IDX_W'(MAX_TOKEN - 1)) begin
      len2  = '0;
      part2 = '0;
    end
    if (end_of_text_i) begin
      len2  = '0;
      part2 = '0;
      abbr2 = 1'b0;
      hyph2 = 1'b0;
      pos3  = '0;
    end
  end

  assign rd_addr   = cur_start_q + k_q;
  assign last_char = k_q == (cur_len_q - IDX_W'(1));
  assign s1_move   = s1_valid_q && (!out_valid_q || !out_stall_i);

  assign status_o.plan_any   = a_valid || b_valid;
  assign status_o.slot_free  = !s1_valid_q || s1_move;
  assign status_o.last_issue = last_char && !pend_valid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && word_class_i) begin
      mem_q[tok_len_q] <= codepoint_i;
    end
    if (cmd_i.issue) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_len_q  <= '0;
      part_q     <= '0;
      abbr_q     <= 1'b0;
      hyph_q     <= 1'b0;
      next_pos_q <= '0;
    end else if (cmd_i.accept) begin
      tok_len_q  <= len2;
      part_q     <= part2;
      abbr_q     <= abbr2;
      hyph_q     <= hyph2;
      next_pos_q <= pos3;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      k_q          <= '0;
    end else if (cmd_i.accept) begin
      k_q          <= '0;
      pend_valid_q <= a_valid && b_valid;
    end else if (cmd_i.issue) begin
      if (last_char) begin
        k_q          <= '0;
        pend_valid_q <= 1'b0;
      end else begin
        k_q <= k_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pend_len_q <= b_len;
      pend_pos_q <= b_pos;
      if (a_valid) begin
        cur_start_q <= a_start;
        cur_len_q   <= a_len;
        cur_pos_q   <= a_pos;
      end else begin
        cur_start_q <= '0;
        cur_len_q   <= b_len;
        cur_pos_q   <= b_pos;
      end
    end else if (cmd_i.issue && last_char && pend_valid_q) begin
      cur_start_q <= '0;
      cur_len_q   <= pend_len_q;
      cur_pos_q   <= pend_pos_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.issue) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      s1_pos_q <= cur_pos_q;
      s1_len_q <= cur_len_q;
      s1_low_q <= last_char;
      s1_lor_q <= last_char && !pend_valid_q;
    end
    if (s1_move) begin
      out_char_q <= rd_q;
      out_pos_q  <= s1_pos_q;
      out_len_q  <= s1_len_q;
      out_low_q  <= s1_low_q;
      out_lor_q  <= s1_lor_q;
    end
  end

  assign len_ext         = LEN_W'(out_len_q);
  assign out_valid_o     = out_valid_q;
  assign out_char_o      = out_char_q;
  assign word_position_o = out_pos_q;
  assign word_length_o   = len_ext[WLEN_W-1:0];
  assign last_of_word_o  = out_low_q;
  assign last_of_run_o   = out_lor_q;

endmodule

// File: hdl/search_word_tokenizer_unit.sv
// Top level of the search word tokenizer.
// Depends on swt_pkg, swt_ctrl and swt_datapath.
//
// Channel  Direction  Handshake             Payload
// in       input      in_valid_i/in_stall_o codepoint_i word_class_i end_of_text_i
// out      output     out_valid_o/out_stall_i out_char_o word_position_o
//                                           word_length_o last_of_word_o last_of_run_o
//
// An item that emits nothing is taken and leaves the input ready. An item that
// emits words stalls the input while its codepoints are read one by one through
// the single token store read port; each passes the staged read, then the output register.
// Reset is asynchronous and leaves the block ready at once, no clearing pass.
// A stall on out holds the output register and the one staged read behind it.
module search_word_tokenizer_unit import swt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CP_W-1:0]   codepoint_i,
  input  logic              word_class_i,
  input  logic              end_of_text_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [CP_W-1:0]   out_char_o,
  output logic [POS_W-1:0]  word_position_o,
  output logic [WLEN_W-1:0] word_length_o,
  output logic              last_of_word_o,
  output logic              last_of_run_o
);

  swt_cmd_t    cmd;
  swt_status_t status;

  swt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  swt_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .codepoint_i     (codepoint_i),
    .word_class_i    (word_class_i),
    .end_of_text_i   (end_of_text_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_char_o      (out_char_o),
    .word_position_o (word_position_o),
    .word_length_o   (word_length_o),
    .last_of_word_o  (last_of_word_o),
    .last_of_run_o   (last_of_run_o)
  );

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Testbench of search_word_tokenizer_unit: directed table and random texts,
// with random idling on both channels. Depends on swt_pkg and the unit itself.
module testbench;
  import swt_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int RANDOM_ITEMS = 400;

  localparam logic [CP_W-1:0] CP_SPACE = 21'h000020;
  localparam logic [CP_W-1:0] CP_COMMA = 21'h00002C;
  localparam logic [CP_W-1:0] CP_TOP   = 21'h10FFFF;
  localparam logic [CP_W-1:0] CH_A     = 21'h000061;

  typedef struct packed {
    logic [CP_W-1:0]   ch;
    logic [POS_W-1:0]  pos;
    logic [WLEN_W-1:0] len;
    logic              low;
    logic              lor;
  } word_char_t;

  typedef struct packed {
    logic [CP_W-1:0]   cp;
    logic              wc;
    logic              eot;
    logic              typed;
    logic              typed_any;
    logic [CP_W-1:0]   ch;
    logic [POS_W-1:0]  pos;
    logic [WLEN_W-1:0] len;
  } dir_row_t;

  localparam int N_ROWS = 24;
  localparam dir_row_t DIR_ROWS [N_ROWS] = '{
    '{CP_DOT,              1'b0, 1'b0, 1'b1, 1'b0, 21'h0,  16'd0, 6'd0},
    '{CP_TOP,              1'b1, 1'b1, 1'b1, 1'b1, CP_TOP, 16'd0, 6'd1},
    '{21'h0,               1'b1, 1'b0, 1'b0, 1'b0, 21'h0,  16'd0, 6'd0},
    '{CP_DOT,              1'b0, 1'b0, 1'b0, 1'b0, 21'h0,  16'd0, 6'd0},
    '{CP_W'(CH_A + 1),     1'b1, 1'b0, 1'b0, 1'b0, 21'h0,  16'd0, 6'd0},
    '{CP_DOT,              1'b0, 1'b0, 1'b0, 1'b0, 21'h0,  16'd0, 6'd0},
    '{CP_SPACE,            1'b0, 1'b0, 1'b0, 1'b0, 21'h0,  16'd0, 6'd0},
    '{CP_W'(CH_A + 3),     1'b1, 1'b0, 1'b0, 1'b0, 21'h0,  16'd0, 6'd0},
    '{CP_APOS,             1'b0, 1'b0, 1'b0, 1'b0, 21'h0,  16'd0, 6'd0},
    '{CP_W'(CH_A + 18),    1'b1, 1'b0, 1'b0, 1'b0, 21'h0,  16'd0, 6'd0},
    '{CP_HYPHEN,           1'b0, 1'b0, 1'b0, 1'b0, 21'h0,  16'd0, 6'd0},
    '{CP_HYPHEN,           1'b0, 1'b0, 1'b0, 1'b0, 21'h0,  16'd0, 6'd0},
    '{CP_W'(CH_A + 23),    1'b1, 1'b0, 1'b0, 1'b0, 21'h0,  16'd0, 6'd0},
    '{CP_COMMA,            1'b0, 1'b0, 1'b0, 1'b0, 21'h0,  16'd0, 6'd0},
    '{CP_W'(CH_A + 4),     1'b1, 1'b0, 1'b0, 1'b0, 21'h0,  16'd0, 6'd0},
    '{CP_HYPHEN,           1'b0, 1'b0, 1'b0, 1'b0, 21'h0,  16'd0, 6'd0},
    '{CP_SPACE,            1'b0, 1'b0, 1'b0, 1'b0, 21'h0,  16'd0, 6'd0},
    '{CP_HYPHEN,           1'b0, 1'b0, 1'b0, 1'b0, 21'h0,  16'd0, 6'd0},
    '{CP_W'(CH_A + 5),     1'b1, 1'b0, 1'b0, 1'b0, 21'h0,  16'd0, 6'd0},
    '{CP_W'(CH_A + 6),     1'b1, 1'b0, 1'b0, 1'b0, 21'h0,  16'd0, 6'd0},
    '{CP_DOT,              1'b0, 1'b0, 1'b0, 1'b0, 21'h0,  16'd0, 6'd0},
    '{CP_DOT,              1'b1, 1'b0, 1'b0, 1'b0, 21'h0,  16'd0, 6'd0},
    '{CP_TOP,              1'b0, 1'b0, 1'b0, 1'b0, 21'h0,  16'd0, 6'd0},
    '{CP_APOS,             1'b0, 1'b1, 1'b0, 1'b0, 21'h0,  16'd0, 6'd0}
  };

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [CP_W-1:0]   codepoint_i = '0;
  logic              word_class_i = 1'b0;
  logic              end_of_text_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [CP_W-1:0]   out_char_o;
  logic [POS_W-1:0]  word_position_o;
  logic [WLEN_W-1:0] word_length_o;
  logic              last_of_word_o;
  logic              last_of_run_o;

  search_word_tokenizer_unit dut (.*);

  always #10 clk_i = ~clk_i;

  word_char_t       expected_chars[$];
  logic [CP_W-1:0]  tok_store [MAX_TOKEN];
  int unsigned      tok_len = 0;
  int unsigned      part_start = 0;
  logic             abbr_flag = 1'b0;
  logic             hyph_flag = 1'b0;
  logic [POS_W-1:0] next_pos = '0;

  bit failed = 1'b0;
  int err_count = 0;
  bit idle_on = 1'b1;
  int stall_left = 0;
  int cycle_count = 0;
  int sent_items = 0;

  function automatic logic [POS_W-1:0] pos_up(input logic [POS_W-1:0] p);
    return (p == '1) ? p : p + 1'b1;
  endfunction

  function automatic logic [POS_W-1:0] pos_down(input logic [POS_W-1:0] p);
    return (p == '0) ? p : p - 1'b1;
  endfunction

  function automatic void push_word(input int unsigned start, input int unsigned len,
                                    input logic [POS_W-1:0] pos);
    word_char_t r;
    for (int unsigned k = 0; k < len; k++) begin
      r.ch  = (start + k < MAX_TOKEN) ? tok_store[start + k] : '0;
      r.pos = pos;
      r.len = WLEN_W'(len);
      r.low = (k + 1 == len);
      r.lor = 1'b0;
      expected_chars.push_back(r);
    end
  endfunction

  // Returns how many codepoints this item emits.
  function automatic int tokenize_step(input logic [CP_W-1:0] cp, input logic wc,
                                       input logic eot);
    int before_n;
    logic end_word;
    logic joined;
    word_char_t r;
    before_n = expected_chars.size();
    end_word = eot;
    if (wc) begin
      if (tok_len < MAX_TOKEN) begin
        tok_store[tok_len] = cp;
        tok_len++;
      end
    end else if (cp == CP_DOT && (tok_len == 1 || abbr_flag)) begin
      abbr_flag = 1'b1;
    end else if (cp == CP_APOS) begin
      abbr_flag = 1'b1;
    end else if (cp == CP_HYPHEN && tok_len > 0) begin
      hyph_flag = 1'b1;
      if (tok_len > part_start) push_word(part_start, tok_len - part_start, next_pos);
      next_pos = pos_up(next_pos);
      part_start = tok_len;
    end else begin
      end_word = 1'b1;
    end

    if (end_word && tok_len > 0) begin
      joined = 1'b1;
      if (hyph_flag) begin
        if (tok_len > part_start) begin
          push_word(part_start, tok_len - part_start, next_pos);
          next_pos = pos_down(next_pos);
        end else begin
          joined = 1'b0;
        end
      end
      if (joined) begin
        push_word(0, tok_len, next_pos);
        next_pos = pos_up(next_pos);
      end
      hyph_flag = 1'b0;
      abbr_flag = 1'b0;
      tok_len = 0;
      part_start = 0;
    end

    if (tok_len >= MAX_TOKEN - 1) begin
      tok_len = 0;
      part_start = 0;
    end

    if (eot) begin
      tok_len = 0;
      part_start = 0;
      abbr_flag = 1'b0;
      hyph_flag = 1'b0;
      next_pos = '0;
    end

    if (expected_chars.size() > before_n) begin
      r = expected_chars.pop_back();
      r.lor = 1'b1;
      expected_chars.push_back(r);
    end
    return expected_chars.size() - before_n;
  endfunction

  // Returns how many codepoints the predictor queued for this transfer.
  task automatic send_item(input logic [CP_W-1:0] cp, input logic wc, input logic eot,
                           output int n_new);
    int gap;
    gap = idle_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    codepoint_i   <= cp;
    word_class_i  <= wc;
    end_of_text_i <= eot;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    n_new = tokenize_step(cp, wc, eot);
    sent_items++;
  endtask

  function automatic logic [CP_W-1:0] pick_word_char();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return CP_W'(CH_A + $urandom_range(0, 25));
      5:             return ($urandom_range(0, 1) == 1) ? CP_TOP : '0;
      6:             return ($urandom_range(0, 1) == 1) ? CP_DOT : CP_HYPHEN;
      default:       return CP_W'($urandom_range(0, 1114111));
    endcase
  endfunction

  function automatic logic [CP_W-1:0] pick_separator();
    case ($urandom_range(0, 9))
      0, 1:    return CP_SPACE;
      2:       return CP_COMMA;
      3, 4:    return CP_DOT;
      5:       return CP_APOS;
      6, 7:    return CP_HYPHEN;
      default: return CP_W'($urandom_range(0, 1114111));
    endcase
  endfunction

  task automatic send_text();
    logic [CP_W-1:0] cps[$];
    logic            wcs[$];
    int n_words;
    int len;
    int n_sep;
    int n_new;
    n_words = $urandom_range(1, 6);
    for (int w = 0; w < n_words; w++) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(26, 34) : $urandom_range(1, 6);
      for (int k = 0; k < len; k++) begin
        cps.push_back(pick_word_char());
        wcs.push_back(1'b1);
        // noise: random item of either class
        if ($urandom_range(0, 19) == 0) begin
          cps.push_back(CP_W'($urandom_range(0, 1114111)));
          wcs.push_back(1'($urandom_range(0, 1)));
        end
      end
      n_sep = $urandom_range(0, 2);
      if (w + 1 < n_words && n_sep == 0) n_sep = 1;
      for (int s = 0; s < n_sep; s++) begin
        cps.push_back(pick_separator());
        wcs.push_back(1'b0);
      end
    end
    foreach (cps[i]) send_item(cps[i], wcs[i], i == cps.size() - 1, n_new);
  endtask

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      failed = 1'b1;
      err_count++;
      // cap the log
      if (err_count <= 100) $error("%s: expected %h, actual %h", name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk_i) begin
    word_char_t e;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (expected_chars.size() == 0) begin
        failed = 1'b1;
        err_count++;
        if (err_count <= 100) $error("out_char: expected none, actual %h", out_char_o);
      end else begin
        e = expected_chars.pop_front();
        check_field("out_char", 32'(e.ch), 32'(out_char_o));
        check_field("word_position", 32'(e.pos), 32'(word_position_o));
        check_field("word_length", 32'(e.len), 32'(word_length_o));
        check_field("last_of_word", 32'(e.low), 32'(last_of_word_o));
        check_field("last_of_run", 32'(e.lor), 32'(last_of_run_o));
      end
      stall_left = idle_on ? $urandom_range(0, 14) : 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end
    out_stall_i <= (stall_left != 0);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    word_char_t t;
    int n_new;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < N_ROWS; i++) begin
      send_item(DIR_ROWS[i].cp, DIR_ROWS[i].wc, DIR_ROWS[i].eot, n_new);
      if (DIR_ROWS[i].typed) begin
        repeat (n_new) void'(expected_chars.pop_back());
        if (DIR_ROWS[i].typed_any) begin
          t = '{DIR_ROWS[i].ch, DIR_ROWS[i].pos, DIR_ROWS[i].len, 1'b1, 1'b1};
          expected_chars.push_back(t);
        end
      end
    end

    sent_items = 0;
    while (sent_items < RANDOM_ITEMS) begin
      idle_on = ($urandom_range(0, 4) != 0);
      send_text();
    end
    in_valid_i <= 1'b0;

    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (!failed) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/swt_pkg.sv
hdl/swt_ctrl.sv
hdl/swt_datapath.sv
hdl/search_word_tokenizer_unit.sv
tb/testbench.sv
